>>> src/roc_pkg.sv
// Package for the rectangle overlap counter.
// Holds the default sizes and the control struct passed along the cell chain.
// No dependencies.
`default_nettype none

package roc_pkg;

   localparam int DEF_MAX_RECTS  = 64;
   localparam int DEF_COORD_BITS = 16;

   // Control that travels with a query from cell to cell.
   typedef struct packed {
      logic valid;   // a query occupies this stage
      logic full;    // the store was full when the query arrived
   } roc_ctrl_type;

endpackage : roc_pkg

`default_nettype wire

>>> src/rectangle_overlap_counter.sv
// Top level of the rectangle overlap counter: a chain of MAX_RECTS cells and
// the result register. Depends on roc_pkg and roc_cell.
//
// Usage: each req beat carries one rectangle in req_tdata (left, bottom,
// right, top from the lowest bit up, COORD_BITS each, two's complement).
// Each rsp beat returns, for that rectangle and in input order, the number of
// earlier stored rectangles that strictly overlap it (rsp_tdata) and a flag
// that the store was full so the rectangle was dropped (rsp_tuser).
// The query walks one cell per cycle down the chain while it is not stalled;
// each cell tests it against its own rectangle, and the first empty cell keeps
// it. A result passes every cell register and then the result register, and a
// new rectangle can be accepted every cycle while the chain is not stalled, so
// the sustained rate without stalls is one item per cycle.
// Reset empties the store and drops everything in flight. When the receiver
// holds rsp_tready low with a result waiting, the whole chain freezes and
// req_tready falls until the result is taken.
`default_nettype none

module rectangle_overlap_counter #(
   parameter int MAX_RECTS  = roc_pkg::DEF_MAX_RECTS,
   parameter int COORD_BITS = roc_pkg::DEF_COORD_BITS,
   localparam int IDX_BITS  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
   localparam int CNT_BITS  = $clog2(MAX_RECTS + 1),
   localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_W     = ((CNT_BITS + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [IN_W-1:0]   req_tdata,   // left, bottom, right, top, zero pad
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [OUT_W-1:0]       rsp_tdata,   // overlap_count, zero pad
   output logic                   rsp_tuser    // store_full
);

   localparam logic [CNT_BITS-1:0] CAPACITY = CNT_BITS'(MAX_RECTS);

   roc_pkg::roc_ctrl_type     ctrl_chain  [0:MAX_RECTS];
   logic [IDX_BITS-1:0]       slot_chain  [0:MAX_RECTS];
   logic [CNT_BITS-1:0]       count_chain [0:MAX_RECTS];
   logic [4*COORD_BITS-1:0]   rect_chain  [0:MAX_RECTS];

   logic                      advance;
   logic                      accept;
   logic                      store_full;
   logic [CNT_BITS-1:0]       stored_count_ff, stored_count_in;
   logic                      out_valid_ff, out_valid_in;
   logic [CNT_BITS-1:0]       out_count_ff;
   logic                      out_full_ff;

   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid & advance;
   assign store_full = (stored_count_ff == CAPACITY);

   always_comb begin
      ctrl_chain[0].valid = req_tvalid;
      ctrl_chain[0].full  = store_full;
      slot_chain[0]       = stored_count_ff[IDX_BITS-1:0];
      count_chain[0]      = '0;
      rect_chain[0]       = req_tdata[4*COORD_BITS-1:0];
      stored_count_in     = stored_count_ff;
      if (accept && !store_full) begin
         stored_count_in = stored_count_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_count_ff <= '0;
      end else begin
         stored_count_ff <= stored_count_in;
      end
   end

   for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
      roc_cell #(
         .CELL_INDEX (i),
         .COORD_BITS (COORD_BITS),
         .IDX_BITS   (IDX_BITS),
         .CNT_BITS   (CNT_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctrl_i  (ctrl_chain[i]),
         .slot_i  (slot_chain[i]),
         .count_i (count_chain[i]),
         .rect_i  (rect_chain[i]),
         .ctrl_o  (ctrl_chain[i+1]),
         .slot_o  (slot_chain[i+1]),
         .count_o (count_chain[i+1]),
         .rect_o  (rect_chain[i+1])
      );
   end

   // The end of the chain carries slot and rectangle that nobody needs.
   logic unused_tail;
   assign unused_tail = ^{slot_chain[MAX_RECTS], rect_chain[MAX_RECTS]};

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = ctrl_chain[MAX_RECTS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_count_ff <= count_chain[MAX_RECTS];
         out_full_ff  <= ctrl_chain[MAX_RECTS].full;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_W'(out_count_ff) | {OUT_W{unused_tail & 1'b0}};
   assign rsp_tuser  = out_full_ff;

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= CAPACITY)
      else $error("stored count exceeds capacity");

   a_full_no_store : assert property (@(posedge clock) disable iff (reset)
      (accept && store_full) |=> $stable(stored_count_ff))
      else $error("rectangle stored while the store was full");

   a_stall_holds_tail : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> $stable(ctrl_chain[MAX_RECTS]))
      else $error("chain moved while the result was stalled");

   a_result_from_chain : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(ctrl_chain[MAX_RECTS].valid))
      else $error("result appeared without a query at the chain end");

   a_count_le_stored : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_full_ff) |-> (out_count_ff < CAPACITY))
      else $error("overlap count too large for a stored rectangle");

endmodule : rectangle_overlap_counter

`default_nettype wire

>>> src/roc_cell.sv
// One cell of the rectangle chain: holds one stored rectangle, tests the
// passing query against it and hands the query on to the next cell.
// Depends on roc_pkg.
`default_nettype none

module roc_cell #(
   parameter int CELL_INDEX = 0,
   parameter int COORD_BITS = roc_pkg::DEF_COORD_BITS,
   parameter int IDX_BITS   = 6,
   parameter int CNT_BITS   = 7
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire roc_pkg::roc_ctrl_type     ctrl_i,
   input  wire logic [IDX_BITS-1:0]       slot_i,
   input  wire logic [CNT_BITS-1:0]       count_i,
   input  wire logic [4*COORD_BITS-1:0]   rect_i,
   output roc_pkg::roc_ctrl_type          ctrl_o,
   output logic [IDX_BITS-1:0]            slot_o,
   output logic [CNT_BITS-1:0]            count_o,
   output logic [4*COORD_BITS-1:0]        rect_o
);

   localparam logic [IDX_BITS-1:0] MY_SLOT = IDX_BITS'(CELL_INDEX);

   roc_pkg::roc_ctrl_type     ctrl_ff, ctrl_in;
   logic [IDX_BITS-1:0]       slot_ff;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [4*COORD_BITS-1:0]   rect_ff;
   logic [4*COORD_BITS-1:0]   stored_ff, stored_in;

   logic signed [COORD_BITS-1:0] q_lx, q_ly, q_hx, q_hy;
   logic signed [COORD_BITS-1:0] s_lx, s_ly, s_hx, s_hy;
   logic                         occupied;
   logic                         overlap;
   logic                         hit;
   logic                         take;

   assign q_lx = rect_i[COORD_BITS-1:0];
   assign q_ly = rect_i[2*COORD_BITS-1:COORD_BITS];
   assign q_hx = rect_i[3*COORD_BITS-1:2*COORD_BITS];
   assign q_hy = rect_i[4*COORD_BITS-1:3*COORD_BITS];
   assign s_lx = stored_ff[COORD_BITS-1:0];
   assign s_ly = stored_ff[2*COORD_BITS-1:COORD_BITS];
   assign s_hx = stored_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign s_hy = stored_ff[4*COORD_BITS-1:3*COORD_BITS];

   // The query's target slot tells whether this cell already held a rectangle
   // when the query was accepted; a full store means every cell is occupied.
   always_comb begin
      occupied  = ctrl_i.full | (slot_i > MY_SLOT);
      overlap   = (q_lx < s_hx) && (s_lx < q_hx) && (q_ly < s_hy) && (s_ly < q_hy);
      hit       = ctrl_i.valid & occupied & overlap;
      take      = advance & ctrl_i.valid & ~ctrl_i.full & (slot_i == MY_SLOT);
      count_in  = count_i + CNT_BITS'(hit);
      ctrl_in   = ctrl_i;
      stored_in = take ? rect_i : stored_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff  <= slot_i;
         count_ff <= count_in;
         rect_ff  <= rect_i;
      end
      stored_ff <= stored_in;
   end

   assign ctrl_o  = ctrl_ff;
   assign slot_o  = slot_ff;
   assign count_o = count_ff;
   assign rect_o  = rect_ff;

endmodule : roc_cell

`default_nettype wire

>>> verif/rectangle_overlap_checker.sv
// Scoreboard for the rectangle overlap counter: predicts each result from the
// accepted req beats and compares it with the rsp beats in order.
// Depends on roc_pkg for the default sizes.
`timescale 1ns / 100ps
`default_nettype none

module rectangle_overlap_checker #(
   parameter int MAX_RECTS  = roc_pkg::DEF_MAX_RECTS,
   parameter int COORD_BITS = roc_pkg::DEF_COORD_BITS,
   parameter int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
   parameter int OUT_W      = (($clog2(MAX_RECTS + 1) + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [IN_W-1:0]  req_tdata,   // left, bottom, right, top, zero pad
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [OUT_W-1:0] rsp_tdata,   // overlap_count, zero pad
   input  wire logic             rsp_tuser,   // store_full
   output int                    fail_count,
   output int                    outstanding,
   output int                    results_checked,
   output int                    full_results,
   output int                    peak_overlap
);

   localparam int CNT_BITS = $clog2(MAX_RECTS + 1);

   // Packed so that left lands in the lowest bits, as on the req bus.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] top;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] bottom;
      logic signed [COORD_BITS-1:0] left;
   } rect_t;

   typedef struct packed {
      logic                store_full;
      logic [CNT_BITS-1:0] overlap_count;
   } overlap_result_t;

   rect_t           rect_bank [MAX_RECTS];
   int              bank_fill;
   overlap_result_t pending_results [$];
   overlap_result_t predicted;
   overlap_result_t oldest;
   rect_t           query;
   int              hits;
   int              slot;

   // Open intervals on both axes, so shared edges and corners do not count.
   function automatic bit strictly_overlaps(rect_t held, rect_t probe);
      return (probe.left < held.right) && (held.left < probe.right) &&
             (probe.bottom < held.top) && (held.bottom < probe.top);
   endfunction

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      full_results    = 0;
      peak_overlap    = 0;
      bank_fill       = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         bank_fill = 0;
         pending_results.delete();
         outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: rsp beat with no result expected, got count %0d full %0b",
                        $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               results_checked++;
               if (rsp_tdata !== OUT_W'(oldest.overlap_count)) begin
                  $display("%0t: overlap_count mismatch, expected %0d, got %0d",
                           $time, oldest.overlap_count, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== oldest.store_full) begin
                  $display("%0t: store_full mismatch, expected %0b, got %0b",
                           $time, oldest.store_full, rsp_tuser);
                  fail_count++;
               end
               if (oldest.store_full)
                  full_results++;
               if (oldest.overlap_count > peak_overlap)
                  peak_overlap = oldest.overlap_count;
            end
         end
         if (req_tvalid && req_tready) begin
            query = rect_t'(req_tdata[4*COORD_BITS-1:0]);
            hits  = 0;
            for (slot = 0; slot < bank_fill; slot++)
               if (strictly_overlaps(rect_bank[slot], query))
                  hits++;
            predicted.overlap_count = hits[CNT_BITS-1:0];
            predicted.store_full    = (bank_fill >= MAX_RECTS);
            if (bank_fill < MAX_RECTS) begin
               rect_bank[bank_fill] = query;
               bank_fill++;
            end
            pending_results.push_back(predicted);
         end
         outstanding = pending_results.size();
      end
   end

endmodule : rectangle_overlap_checker

`default_nettype wire

>>> verif/rectangle_overlap_counter_tb.sv
// Top of the rectangle overlap counter regression: clock, reset, req and rsp
// traffic with random idling and a long rsp hold-off, and the final verdict.
// Depends on roc_pkg, rectangle_overlap_counter and rectangle_overlap_checker.
`timescale 1ns / 100ps
`default_nettype none

module rectangle_overlap_counter_tb;

   localparam int MAX_RECTS    = roc_pkg::DEF_MAX_RECTS;
   localparam int COORD_BITS   = roc_pkg::DEF_COORD_BITS;
   localparam int IN_W         = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int OUT_W        = (($clog2(MAX_RECTS + 1) + 7) / 8) * 8;
   localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
   localparam int RANDOM_RECTS = 1380;
   localparam int HOLD_START   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int STEADY_FIRST = 700;
   localparam int STEADY_LAST  = 1000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RECENT_DEPTH = 16;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata;    // left, bottom, right, top, zero pad
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [OUT_W-1:0] rsp_tdata;    // overlap_count, zero pad
   logic             rsp_tuser;    // store_full

   int fail_count;
   int outstanding;
   int results_checked;
   int full_results;
   int peak_overlap;
   int rects_sent;
   int cycle_count;
   bit rsp_held_off;
   int recent_fill;
   logic [IN_W-1:0] recent_rects [RECENT_DEPTH];

   rectangle_overlap_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rectangle_overlap_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .full_results    (full_results),
      .peak_overlap    (peak_overlap)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [IN_W-1:0] pack_rect(int left, int bottom, int right, int top);
      return {top[COORD_BITS-1:0], right[COORD_BITS-1:0],
              bottom[COORD_BITS-1:0], left[COORD_BITS-1:0]};
   endfunction

   function automatic int coord_of(logic [IN_W-1:0] beat, int index);
      logic signed [COORD_BITS-1:0] raw;
      raw = beat[index*COORD_BITS +: COORD_BITS];
      return raw;
   endfunction

   function automatic bit steady_window();
      return (rects_sent >= STEADY_FIRST) && (rects_sent < STEADY_LAST);
   endfunction

   // Most rectangles live in a small area around the origin so that shared
   // edges and deep overlap stacks are common; a few use the whole range.
   function automatic logic [IN_W-1:0] random_rect();
      int kind;
      int left;
      int bottom;
      int right;
      int top;
      int swap;
      logic [IN_W-1:0] seed_rect;
      kind   = $urandom_range(0, 99);
      left   = $urandom_range(0, 40);
      left   = left - 20;
      bottom = $urandom_range(0, 40);
      bottom = bottom - 20;
      right  = left + $urandom_range(0, 24);
      top    = bottom + $urandom_range(0, 24);
      if (kind < 50) begin
         if ($urandom_range(0, 9) == 0) begin
            swap = left; left = right; right = swap;
         end
         if ($urandom_range(0, 9) == 0) begin
            swap = bottom; bottom = top; top = swap;
         end
      end else if (kind < 65) begin
         left   = left - 30;
         bottom = bottom - 30;
         right  = left + $urandom_range(20, 80);
         top    = bottom + $urandom_range(20, 80);
      end else if (kind < 85 && recent_fill > 0) begin
         // Share one edge of a recent rectangle exactly.
         seed_rect = recent_rects[$urandom_range(0, recent_fill - 1)];
         case ($urandom_range(0, 3))
            0: begin
               left  = coord_of(seed_rect, 2);
               right = left + $urandom_range(1, 20);
            end
            1: begin
               right = coord_of(seed_rect, 0);
               left  = right - $urandom_range(1, 20);
            end
            2: begin
               bottom = coord_of(seed_rect, 3);
               top    = bottom + $urandom_range(1, 20);
            end
            default: begin
               top    = coord_of(seed_rect, 1);
               bottom = top - $urandom_range(1, 20);
            end
         endcase
      end else begin
         return {$urandom, $urandom};
      end
      return pack_rect(left, bottom, right, top);
   endfunction

   task automatic send_rect(input logic [IN_W-1:0] beat);
      @(negedge clock);
      while (!steady_window() && $urandom_range(0, 99) < 27) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = beat;
      do @(posedge clock); while (!req_tready);
      rects_sent++;
      recent_rects[rects_sent % RECENT_DEPTH] = beat;
      if (recent_fill < RECENT_DEPTH)
         recent_fill++;
   endtask

   // Receiver: random stalls, one long hold-off that backs the chain up into
   // the req side, and no stalls at all inside the steady window.
   initial begin
      rsp_tready   = 1'b0;
      rsp_held_off = 1'b0;
      forever begin
         @(negedge clock);
         if (!rsp_held_off && rects_sent >= HOLD_START) begin
            rsp_held_off = 1'b1;
            rsp_tready   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready = steady_window() || ($urandom_range(0, 99) >= 27);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("rectangle_overlap_counter regression: fail");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rects_sent  = 0;
      recent_fill = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Touching edges and corners, a stack over all of them, degenerate
      // rectangles, and the corners of the coordinate range.
      send_rect(pack_rect(0, 0, 10, 10));
      send_rect(pack_rect(10, 0, 20, 10));
      send_rect(pack_rect(0, 10, 10, 20));
      send_rect(pack_rect(10, 10, 20, 20));
      send_rect(pack_rect(5, 5, 15, 15));
      send_rect(pack_rect(15, 15, 5, 5));
      send_rect(pack_rect(5, 0, 5, 20));
      send_rect(pack_rect(10, 0, 0, 10));
      send_rect(pack_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_rect(pack_rect(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_rect(pack_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_rect(pack_rect(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN + 1));
      send_rect(pack_rect(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX));
      send_rect(pack_rect(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      send_rect(pack_rect(-10, -10, -1, -1));
      send_rect(pack_rect(-5, -5, 5, 5));
      send_rect(pack_rect(-1, -1, 0, 0));
      send_rect(pack_rect(0, 0, 1, 1));
      send_rect(pack_rect(0, 0, 10, 10));
      send_rect(pack_rect(COORD_MIN, -3, COORD_MAX, 3));

      repeat (RANDOM_RECTS) send_rect(random_rect());

      @(negedge clock);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (MAX_RECTS + 20) @(negedge clock);

      $display("Sent %0d rectangles; %0d results checked, %0d of them with the store full,",
               rects_sent, results_checked, full_results);
      $display("largest overlap count seen %0d, %0d cycles in all.", peak_overlap, cycle_count);
      if (fail_count == 0)
         $display("rectangle_overlap_counter regression: pass");
      else
         $display("rectangle_overlap_counter regression: fail");
      $finish;
   end

endmodule : rectangle_overlap_counter_tb

`default_nettype wire

>>> filelist.f
src/roc_pkg.sv
src/roc_cell.sv
src/rectangle_overlap_counter.sv
verif/rectangle_overlap_checker.sv
verif/rectangle_overlap_counter_tb.sv
